### hdl/brm_pkg.sv
package brm_pkg;

	typedef struct packed {
		logic        req_type;
		logic [3:0]  opcode;
		logic [7:0]  reg_a;
		logic [7:0]  reg_b;
		logic [7:0]  reg_c_or_cmp;
		logic [15:0] target;
		logic signed [31:0] in_value;
	} in_item_t;

	typedef struct packed {
		logic [15:0] next_pc;
		logic        out_valid;
		logic        out_is_char;
		logic signed [31:0] out_value;
		logic        div_by_zero;
	} out_item_t;

	localparam logic [3:0] OP_MOVE  = 4'd0;
	localparam logic [3:0] OP_ADD   = 4'd2;
	localparam logic [3:0] OP_SUB   = 4'd3;
	localparam logic [3:0] OP_MUL   = 4'd4;
	localparam logic [3:0] OP_DIV   = 4'd5;
	localparam logic [3:0] OP_MOD   = 4'd6;
	localparam logic [3:0] OP_STORE = 4'd7;
	localparam logic [3:0] OP_LOAD  = 4'd8;
	localparam logic [3:0] OP_BRF   = 4'd9;
	localparam logic [3:0] OP_JUMP  = 4'd10;
	localparam logic [3:0] OP_RDCH  = 4'd12;
	localparam logic [3:0] OP_WRCH  = 4'd13;
	localparam logic [3:0] OP_RDINT = 4'd14;
	localparam logic [3:0] OP_WRINT = 4'd15;

	localparam logic [7:0] CMP_LT = 8'd0;
	localparam logic [7:0] CMP_LE = 8'd1;
	localparam logic [7:0] CMP_EQ = 8'd2;
	localparam logic [7:0] CMP_GE = 8'd3;
	localparam logic [7:0] CMP_GT = 8'd4;
	localparam logic [7:0] CMP_NE = 8'd5;

endpackage

### hdl/bytecode_register_machine_core_unit.sv
// bytecode register machine core
// in channel (in, in_valid, in_stall): one instruction or register preload per
// transaction; the fetcher supplies the instruction at the last reported next_pc.
// out channel (out, out_valid, out_stall): exactly one result per input
// transaction, carrying next_pc, an optional output-stream value and the
// divide-by-zero flag.
// one item at a time: read registers (states RA, RB, RC, one register-file port
// read three times), read the data memory (state MEM), execute, write back.
// div and mod add the radix-2 iterative divider (state DIV); mul adds the
// registered product (state MUL).
// a new input is taken only after the previous item has been executed.
// the register file has one read and one write port; the data memory is a single-port synchronous memory.
// after reset both memories are cleared, one entry per cycle, over
// max(NUM_REGS, 2^MEM_ADDR_BITS) entries (1024 by default); no input is
// taken meanwhile. the pc resets to zero.
// a result waits in the output register while out_stall is high; the next
// input is accepted at the edge where the previous result is taken.
module bytecode_register_machine_core_unit #(
	parameter int NUM_REGS      = 256,
	parameter int MEM_ADDR_BITS = 10,
	parameter int PC_BITS       = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  brm_pkg::in_item_t   in,
	input  logic                in_valid,
	output logic                in_stall,
	output brm_pkg::out_item_t  out,
	output logic                out_valid,
	input  logic                out_stall
);
	import brm_pkg::*;

	localparam int RB  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int CLB = (RB > MEM_ADDR_BITS ? RB : MEM_ADDR_BITS) + 1;
	localparam int MEM_WORDS = 1 << MEM_ADDR_BITS;
	localparam int CLR_N = (NUM_REGS > MEM_WORDS) ? NUM_REGS : MEM_WORDS;

	typedef enum logic [8:0] {
		ST_CLR  = 9'b000000001,
		ST_IDLE = 9'b000000010,
		ST_RA   = 9'b000000100,
		ST_RB   = 9'b000001000,
		ST_RC   = 9'b000010000,
		ST_MEM  = 9'b000100000,
		ST_MUL  = 9'b001000000,
		ST_DIV  = 9'b010000000,
		ST_EXE  = 9'b100000000
	} state_t;

	state_t state_q;
	in_item_t it_q;
	logic [CLB-1:0] clr_q;
	logic [PC_BITS-1:0] pc_q;
	logic [31:0] va_q, vb_q, vc_q, res_q, rdata, mdata;
	logic [31:0] rf [NUM_REGS];
	logic [31:0] dm [MEM_WORDS];
	logic [RB-1:0] raddr, waddr;
	logic rwe;
	logic [31:0] rwdata;
	logic [MEM_ADDR_BITS-1:0] maddr;
	logic mwe;
	logic [31:0] mwdata;
	logic [5:0] dcnt_q;
	logic [31:0] quo_q, rem_q, dvs_q;
	logic dneg_q, rneg_q;
	logic out_valid_q;
	out_item_t out_q;

	// register index in range
	function automatic logic in_rng(input logic [7:0] idx);
		in_rng = ({24'd0, idx} < 32'(NUM_REGS));
	endfunction

	assign in_stall  = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign out_valid = out_valid_q;
	assign out       = out_q;

	always_comb begin
		raddr = RB'(it_q.reg_a);
		case (state_q)
			ST_RB:   raddr = RB'(it_q.reg_b);
			ST_RC:   raddr = RB'(it_q.reg_c_or_cmp);
			default: raddr = RB'(it_q.reg_a);
		endcase
	end

	always_ff @(posedge clk) begin
		if (rwe) begin
			rf[waddr] <= rwdata;
		end
		rdata <= rf[raddr];
	end

	always_ff @(posedge clk) begin
		if (mwe) begin
			dm[maddr] <= mwdata;
		end
		mdata <= dm[maddr];
	end

	// execute result
	logic [31:0] vb_eff, vc_eff, va_eff;
	logic cmp_ok, lt_ab, lt_ba;
	logic wr_reg;
	logic [31:0] wval;
	logic [PC_BITS-1:0] npc;
	out_item_t oi;
	logic [31:0] prod;
	logic [32:0] dtry;

	assign va_eff = in_rng(it_q.reg_a) ? va_q : 32'd0;
	assign vb_eff = in_rng(it_q.reg_b) ? vb_q : 32'd0;
	assign vc_eff = in_rng(it_q.reg_c_or_cmp) ? vc_q : 32'd0;
	assign lt_ab  = $signed(va_eff) < $signed(vb_eff);
	assign lt_ba  = $signed(vb_eff) < $signed(va_eff);
	assign prod   = vb_eff * vc_eff;
	assign dtry   = {rem_q, quo_q[31]} - {1'b0, dvs_q};

	always_comb begin
		case (it_q.reg_c_or_cmp)
			CMP_LT:  cmp_ok = lt_ab;
			CMP_LE:  cmp_ok = !lt_ba;
			CMP_EQ:  cmp_ok = va_eff == vb_eff;
			CMP_GE:  cmp_ok = !lt_ab;
			CMP_GT:  cmp_ok = lt_ba;
			CMP_NE:  cmp_ok = va_eff != vb_eff;
			default: cmp_ok = 1'b0;
		endcase
	end

	always_comb begin
		wr_reg = 1'b0;
		wval   = 32'd0;
		npc    = pc_q + PC_BITS'(1);
		oi     = '0;
		mwe    = 1'b0;
		mwdata = vb_q;
		maddr  = (state_q == ST_CLR) ? MEM_ADDR_BITS'(clr_q) :
			(it_q.opcode == OP_STORE) ? va_eff[MEM_ADDR_BITS-1:0] :
			vb_eff[MEM_ADDR_BITS-1:0];
		if (state_q == ST_EXE) begin
			if (it_q.req_type) begin
				wr_reg = 1'b1;
				wval   = it_q.in_value;
				npc    = pc_q;
			end else begin
				case (it_q.opcode)
					OP_MOVE:  begin wr_reg = 1'b1; wval = vb_eff; end
					OP_ADD:   begin wr_reg = 1'b1; wval = vb_eff + vc_eff; end
					OP_SUB:   begin wr_reg = 1'b1; wval = vb_eff - vc_eff; end
					OP_MUL:   begin wr_reg = 1'b1; wval = res_q; end
					OP_DIV, OP_MOD: begin
						wr_reg = 1'b1;
						oi.div_by_zero = (vc_eff == 32'd0);
						wval = oi.div_by_zero ? 32'd0 : res_q;
					end
					OP_STORE: mwe = 1'b1;
					OP_LOAD:  begin wr_reg = 1'b1; wval = mdata; end
					OP_BRF:   if (!cmp_ok) npc = PC_BITS'(it_q.target);
					OP_JUMP:  npc = PC_BITS'(it_q.target);
					OP_RDCH:  begin
						wr_reg = 1'b1;
						wval = {{24{it_q.in_value[7]}}, it_q.in_value[7:0]};
					end
					OP_WRCH:  begin
						oi.out_valid = 1'b1; oi.out_is_char = 1'b1;
						oi.out_value = {24'd0, va_eff[7:0]};
					end
					OP_RDINT: begin wr_reg = 1'b1; wval = it_q.in_value; end
					OP_WRINT: begin oi.out_valid = 1'b1; oi.out_value = va_eff; end
					default:  ;
				endcase
			end
		end
		oi.next_pc = 16'(npc);
		if (state_q == ST_CLR) begin
			mwe    = 1'b1;
			mwdata = 32'd0;
		end
	end

	always_comb begin
		rwe    = 1'b0;
		waddr  = RB'(it_q.reg_a);
		rwdata = wval;
		if (state_q == ST_CLR) begin
			rwe    = (clr_q < CLB'(NUM_REGS));
			waddr  = RB'(clr_q);
			rwdata = 32'd0;
		end else if (wr_reg && in_rng(it_q.reg_a)) begin
			rwe = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			pc_q        <= '0;
			out_valid_q <= 1'b0;
			dcnt_q      <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + CLB'(1);
					if (clr_q == CLB'(CLR_N - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: if (in_valid && !in_stall) begin
					state_q <= ST_RA;
				end
				ST_RA: state_q <= ST_RB;
				ST_RB: state_q <= ST_RC;
				ST_RC: state_q <= ST_MEM;
				ST_MEM: begin
					if (!it_q.req_type && it_q.opcode == OP_MUL) begin
						state_q <= ST_MUL;
					end else if (!it_q.req_type &&
						(it_q.opcode == OP_DIV || it_q.opcode == OP_MOD)) begin
						state_q <= ST_DIV;
						dcnt_q  <= '0;
					end else begin
						state_q <= ST_EXE;
					end
				end
				ST_MUL: state_q <= ST_EXE;
				ST_DIV: begin
					dcnt_q <= dcnt_q + 6'd1;
					if (dcnt_q == 6'd33) begin
						state_q <= ST_EXE;
					end
				end
				ST_EXE: begin
					pc_q        <= npc;
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_CLR;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid && !in_stall) begin
			it_q <= in;
		end
		if (state_q == ST_RB) va_q <= rdata;
		if (state_q == ST_RC) vb_q <= rdata;
		if (state_q == ST_MEM) vc_q <= rdata;
		if (state_q == ST_MUL) res_q <= prod;
		if (state_q == ST_DIV) begin
			if (dcnt_q == 6'd0) begin
				quo_q  <= vb_eff[31] ? 32'd0 - vb_eff : vb_eff;
				rem_q  <= '0;
				dvs_q  <= vc_eff[31] ? 32'd0 - vc_eff : vc_eff;
				dneg_q <= vb_eff[31] ^ vc_eff[31];
				rneg_q <= vb_eff[31];
			end else if (dcnt_q == 6'd33) begin
				if (it_q.opcode == OP_MOD) begin
					res_q <= rneg_q ? 32'd0 - rem_q : rem_q;
				end else begin
					res_q <= dneg_q ? 32'd0 - quo_q : quo_q;
				end
			end else begin
				if (!dtry[32]) begin
					rem_q <= dtry[31:0];
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= {rem_q[30:0], quo_q[31]};
					quo_q <= {quo_q[30:0], 1'b0};
				end
			end
		end
		if (state_q == ST_EXE) out_q <= oi;
	end

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall)
		else $error("input taken while busy");
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXE) |=> out_valid)
		else $error("result missing after execute");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out)))
		else $error("stalled result changed");
	a_noclr_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !rwe && !mwe)
		else $error("write while idle");

endmodule
